FILE: design/pfe_pkg.sv
// ----------------------------------------------------------------------------
// Formatter package
// Shared types, character constants and lookup functions used by the front
// end, the command queue and the emitter of the format engine.
// ----------------------------------------------------------------------------
package pfe_pkg;

  // Field width limit, position limit and buffer size reset value.
  localparam logic [5:0]  MAX_WIDTH   = 6'd63;
  localparam logic [30:0] POS_MAX     = 31'h7FFF_FFFF;
  localparam logic [30:0] BSIZE_RESET = 31'd4096;

  // Configuration port.
  localparam int unsigned CFG_AW          = 3;
  localparam logic        REG_BUFFER_SIZE = 1'b0;

  // Command queue depth.
  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned CQ_AW    = $clog2(CQ_DEPTH);

  // Input word opcodes; the last code is unused and ignored by the engine.
  localparam logic [1:0] OP_FMT  = 2'd0;
  localparam logic [1:0] OP_ARG  = 2'd1;
  localparam logic [1:0] OP_STR  = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  // Characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_S     = 8'h73;

  // Body of an emit command.
  typedef enum logic [3:0] {
    B_NONE, B_CHAR, B_PCT2, B_DEC, B_UDEC, B_HEXL, B_HEXU, B_PTR, B_NULL, B_TERM
  } body_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [31:0] arg_value;
    logic        arg_null;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic [30:0] out_pos;
    logic        stored;
    logic        last;
    logic        finished;
    logic [30:0] total_count;
  } out_item_t;

  // One command per accepted word that produces output.
  typedef struct packed {
    body_t       body;
    logic [31:0] value;
    logic [5:0]  width;
    logic        left;
    logic        zero_fill;
    logic        explicit_pad;
    logic [5:0]  lead_n;
    logic [5:0]  trail_n;
  } cmd_t;

  // Digit value to character.
  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      c = 8'h37 + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

  // Text printed for a null string.
  function automatic logic [7:0] null_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h28;
      4'd1:    c = 8'h6E;
      4'd2:    c = 8'h75;
      4'd3:    c = 8'h6C;
      4'd4:    c = 8'h6C;
      4'd5:    c = 8'h29;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

FILE: design/pfe_front.sv
// ----------------------------------------------------------------------------
// Format parser
// Accepts input words, tracks the format phase, flags and width, and turns
// each word that produces output into one emit command.
// ----------------------------------------------------------------------------
module pfe_front import pfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  output logic     q_push,
  output cmd_t     q_wdata,
  input  logic     q_full
);

  typedef enum logic [2:0] {PH_LIT, PH_FLAGS, PH_WIDTH, PH_ARG, PH_STR} phase_t;
  typedef enum logic [2:0] {K_D, K_U, K_LX, K_UX, K_P, K_C, K_S} kind_t;

  phase_t      phase_r, phase_nxt;
  kind_t       kind_r, kind_nxt;
  logic        zero_r, zero_nxt;
  logic        left_r, left_nxt;
  logic [5:0]  width_r, width_nxt;
  logic [31:0] sleft_r, sleft_nxt;
  logic [5:0]  tpad_r, tpad_nxt;

  logic        accept;
  logic [7:0]  c;
  logic [9:0]  wsum;
  logic [5:0]  spad;
  logic [31:0] sl_dec;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign c       = in_data.data_byte;

  // Width accumulation, times ten plus the new digit.
  assign wsum = ({4'd0, width_r} << 3) + ({4'd0, width_r} << 1) + {6'd0, c[3:0]};

  // Padding for a string of the given length.
  assign spad = ({26'd0, width_r} > in_data.arg_value) ?
                (width_r - in_data.arg_value[5:0]) : 6'd0;

  assign sl_dec = (sleft_r != 32'd0) ? (sleft_r - 32'd1) : sleft_r;

  // Next state and command.
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    zero_nxt  = zero_r;
    left_nxt  = left_r;
    width_nxt = width_r;
    sleft_nxt = sleft_r;
    tpad_nxt  = tpad_r;
    q_push    = 1'b0;
    q_wdata   = '0;
    q_wdata.body      = B_NONE;
    q_wdata.width     = width_r;
    q_wdata.left      = left_r;
    q_wdata.zero_fill = zero_r;
    q_wdata.value     = in_data.arg_value;

    case (in_data.opcode)
      OP_FMT: begin
        if (c == CH_NUL) begin
          if (phase_r == PH_LIT || phase_r == PH_FLAGS || phase_r == PH_WIDTH) begin
            q_push        = 1'b1;
            q_wdata.body  = B_TERM;
            phase_nxt     = PH_LIT;
            kind_nxt      = K_D;
            zero_nxt      = 1'b0;
            left_nxt      = 1'b0;
            width_nxt     = 6'd0;
            sleft_nxt     = 32'd0;
            tpad_nxt      = 6'd0;
          end
        end else if (phase_r == PH_LIT) begin
          if (c == CH_PCT) begin
            phase_nxt = PH_FLAGS;
          end else begin
            q_push        = 1'b1;
            q_wdata.body  = B_CHAR;
            q_wdata.value = {24'd0, c};
            q_wdata.width = 6'd0;
          end
        end else if (phase_r == PH_FLAGS && c == CH_ZERO) begin
          zero_nxt = 1'b1;
        end else if (phase_r == PH_FLAGS && c == CH_MINUS) begin
          left_nxt = 1'b1;
        end else if (phase_r == PH_FLAGS || phase_r == PH_WIDTH) begin
          phase_nxt = PH_WIDTH;
          if (c >= CH_ZERO && c <= CH_NINE) begin
            width_nxt = (wsum > {4'd0, MAX_WIDTH}) ? MAX_WIDTH : wsum[5:0];
          end else begin
            // Conversion character; left alignment cancels zero padding.
            zero_nxt  = zero_r & ~left_r;
            phase_nxt = PH_ARG;
            case (c)
              CH_D, CH_I: kind_nxt = K_D;
              CH_U:       kind_nxt = K_U;
              CH_LX:      kind_nxt = K_LX;
              CH_UX:      kind_nxt = K_UX;
              CH_P:       kind_nxt = K_P;
              CH_C:       kind_nxt = K_C;
              CH_S:       kind_nxt = K_S;
              CH_PCT: begin
                q_push        = 1'b1;
                q_wdata.body  = B_CHAR;
                q_wdata.value = {24'd0, CH_PCT};
                q_wdata.width = 6'd0;
                phase_nxt     = PH_LIT;
                zero_nxt      = 1'b0;
                left_nxt      = 1'b0;
                width_nxt     = 6'd0;
              end
              default: begin
                q_push        = 1'b1;
                q_wdata.body  = B_PCT2;
                q_wdata.value = {24'd0, c};
                q_wdata.width = 6'd0;
                phase_nxt     = PH_LIT;
                zero_nxt      = 1'b0;
                left_nxt      = 1'b0;
                width_nxt     = 6'd0;
              end
            endcase
          end
        end
      end
      OP_ARG: begin
        if (phase_r == PH_ARG) begin
          phase_nxt = PH_LIT;
          zero_nxt  = 1'b0;
          left_nxt  = 1'b0;
          width_nxt = 6'd0;
          q_push    = 1'b1;
          case (kind_r)
            K_D:  q_wdata.body = B_DEC;
            K_U:  q_wdata.body = B_UDEC;
            K_LX: q_wdata.body = B_HEXL;
            K_UX: q_wdata.body = B_HEXU;
            K_P:  q_wdata.body = B_PTR;
            K_C:  q_wdata.body = B_CHAR;
            K_S: begin
              if (in_data.arg_null) begin
                q_wdata.body = B_NULL;
              end else begin
                q_wdata.body         = B_NONE;
                q_wdata.explicit_pad = 1'b1;
                q_wdata.lead_n       = left_r ? 6'd0 : spad;
                if (in_data.arg_value == 32'd0) begin
                  q_wdata.trail_n = left_r ? spad : 6'd0;
                  q_push          = (spad != 6'd0);
                end else begin
                  q_push    = (!left_r && spad != 6'd0);
                  sleft_nxt = in_data.arg_value;
                  tpad_nxt  = left_r ? spad : 6'd0;
                  phase_nxt = PH_STR;
                  zero_nxt  = zero_r;
                  left_nxt  = left_r;
                  width_nxt = width_r;
                end
              end
            end
            default: q_push = 1'b0;
          endcase
        end
      end
      OP_STR: begin
        if (phase_r == PH_STR) begin
          q_push               = 1'b1;
          q_wdata.body         = B_CHAR;
          q_wdata.value        = {24'd0, c};
          q_wdata.explicit_pad = 1'b1;
          sleft_nxt            = sl_dec;
          if (sl_dec == 32'd0) begin
            q_wdata.trail_n = tpad_r;
            tpad_nxt        = 6'd0;
            phase_nxt       = PH_LIT;
            zero_nxt        = 1'b0;
            left_nxt        = 1'b0;
            width_nxt       = 6'd0;
          end
        end
      end
      default: q_push = 1'b0;
    endcase

    if (!accept) begin
      q_push = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LIT;
      kind_r  <= K_D;
      zero_r  <= 1'b0;
      left_r  <= 1'b0;
      width_r <= 6'd0;
      sleft_r <= 32'd0;
      tpad_r  <= 6'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      zero_r  <= zero_nxt;
      left_r  <= left_nxt;
      width_r <= width_nxt;
      sleft_r <= sleft_nxt;
      tpad_r  <= tpad_nxt;
    end
  end

endmodule

FILE: design/pfe_cmdq.sv
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer of emit commands between the parser and
// the emitter.
// ----------------------------------------------------------------------------
module pfe_cmdq import pfe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);

  cmd_t             mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wp_r, wp_nxt;
  logic [CQ_AW-1:0] rp_r, rp_nxt;
  logic [CQ_AW:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CQ_AW'(0) + (CQ_AW+1)'(CQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  // Pointer and fill count.
  always_comb begin
    wp_nxt  = do_push ? wp_r + CQ_AW'(1) : wp_r;
    rp_nxt  = do_pop  ? rp_r + CQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + (CQ_AW+1)'(do_push) - (CQ_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (CQ_AW+1)'(CQ_DEPTH))
    else $error("command queue overfilled");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + (CQ_AW+1)'(1)))
    else $error("queue count did not follow a push");
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !do_pop)
    else $error("pop from empty queue");

endmodule

FILE: design/pfe_back.sv
// ----------------------------------------------------------------------------
// Character emitter
// Takes emit commands, converts numbers to digits one per cycle, then, unless
// stalled, emits pad and body characters one per cycle with buffer positions.
// ----------------------------------------------------------------------------
module pfe_back import pfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [30:0] bsize,
  input  logic        q_empty,
  input  cmd_t        q_rdata,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_data
);

  typedef enum logic [2:0] {S_IDLE, S_CONV, S_PREP, S_EMIT, S_TERM} state_t;

  state_t      state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [3:0]  dig_r [10];
  logic        neg_r, neg_nxt;
  logic [1:0]  pl_r, pl_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [5:0]  lead_r, lead_nxt;
  logic [5:0]  trail_r, trail_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [30:0] pos_r, pos_nxt;
  out_item_t   out_r, out_nxt;
  logic        ov_r, ov_nxt;

  logic        adv, emit, dig_we;
  logic        is_dec;
  logic [63:0] prod;
  logic [31:0] quo, q10;
  logic [3:0]  digit;
  logic [3:0]  body_len, dsel;
  logic [5:0]  pad;
  logic [7:0]  body_char, ech;
  logic [30:0] pos_inc;

  assign out_empty = !ov_r;
  assign out_data  = out_r;
  assign adv       = !ov_r || out_pop;

  // One digit step: divide by ten through the reciprocal, or shift a nibble.
  assign is_dec = (cmd_r.body == B_DEC) || (cmd_r.body == B_UDEC);
  assign prod   = {32'd0, mag_r} * 64'h0000_0000_CCCC_CCCD;
  assign quo    = {3'd0, prod[63:35]};
  assign q10    = (quo << 3) + (quo << 1);
  assign digit  = is_dec ? (mag_r[3:0] - q10[3:0]) : mag_r[3:0];

  // Body length before padding is worked out.
  always_comb begin
    case (cmd_r.body)
      B_CHAR:  body_len = 4'd1;
      B_PCT2:  body_len = 4'd2;
      B_NULL:  body_len = 4'd6;
      B_DEC, B_UDEC, B_HEXL, B_HEXU, B_PTR: body_len = {2'd0, pl_r} + k_r;
      default: body_len = 4'd0;
    endcase
  end
  assign pad = (cmd_r.width > {2'd0, body_len}) ? (cmd_r.width - {2'd0, body_len}) : 6'd0;

  // Body character at the current index.
  assign dsel = k_r - 4'd1 - (idx_r - {2'd0, pl_r});
  always_comb begin
    case (cmd_r.body)
      B_CHAR:  body_char = cmd_r.value[7:0];
      B_PCT2:  body_char = (idx_r == 4'd0) ? CH_PCT : cmd_r.value[7:0];
      B_NULL:  body_char = null_char(idx_r);
      B_DEC, B_UDEC, B_HEXL, B_HEXU, B_PTR: begin
        if (idx_r < {2'd0, pl_r}) begin
          if (cmd_r.body == B_PTR) begin
            body_char = (idx_r == 4'd0) ? CH_ZERO : CH_LX;
          end else begin
            body_char = CH_MINUS;
          end
        end else begin
          body_char = hex_char(dig_r[dsel], cmd_r.body == B_HEXU);
        end
      end
      default: body_char = CH_SPACE;
    endcase
  end

  assign ech = (lead_r != 6'd0) ? (cmd_r.zero_fill ? CH_ZERO : CH_SPACE) :
               (idx_r < len_r)  ? body_char : CH_SPACE;
  assign pos_inc = (pos_r < POS_MAX) ? pos_r + 31'd1 : pos_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    mag_nxt   = mag_r;
    k_nxt     = k_r;
    neg_nxt   = neg_r;
    pl_nxt    = pl_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    lead_nxt  = lead_r;
    trail_nxt = trail_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    out_nxt   = out_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    dig_we    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_rdata;
          k_nxt   = 4'd0;
          neg_nxt = 1'b0;
          mag_nxt = q_rdata.value;
          case (q_rdata.body)
            B_DEC: begin
              neg_nxt   = q_rdata.value[31];
              mag_nxt   = q_rdata.value[31] ? (~q_rdata.value + 32'd1) : q_rdata.value;
              state_nxt = S_CONV;
            end
            B_UDEC, B_HEXL, B_HEXU, B_PTR: state_nxt = S_CONV;
            B_TERM:  state_nxt = S_TERM;
            default: state_nxt = S_PREP;
          endcase
        end
      end
      S_CONV: begin
        dig_we  = 1'b1;
        k_nxt   = k_r + 4'd1;
        mag_nxt = is_dec ? quo : (mag_r >> 4);
        if (mag_nxt == 32'd0) begin
          state_nxt = S_PREP;
        end
        pl_nxt = (cmd_r.body == B_PTR) ? 2'd2 : ((cmd_r.body == B_DEC && neg_r) ? 2'd1 : 2'd0);
      end
      S_PREP: begin
        len_nxt = body_len;
        idx_nxt = 4'd0;
        if (cmd_r.explicit_pad) begin
          lead_nxt  = cmd_r.lead_n;
          trail_nxt = cmd_r.trail_n;
        end else begin
          lead_nxt  = cmd_r.left ? 6'd0 : pad;
          trail_nxt = cmd_r.left ? pad : 6'd0;
        end
        rem_nxt   = {1'b0, lead_nxt} + {3'd0, body_len} + {1'b0, trail_nxt};
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (adv) begin
          emit                = 1'b1;
          out_nxt.out_char    = ech;
          out_nxt.out_pos     = pos_r;
          out_nxt.stored      = ({1'b0, pos_r} + 32'd1) < {1'b0, bsize};
          out_nxt.last        = (rem_r == 7'd1);
          out_nxt.finished    = 1'b0;
          out_nxt.total_count = 31'd0;
          pos_nxt             = pos_inc;
          rem_nxt             = rem_r - 7'd1;
          if (lead_r != 6'd0) begin
            lead_nxt = lead_r - 6'd1;
          end else if (idx_r < len_r) begin
            idx_nxt = idx_r + 4'd1;
          end else begin
            trail_nxt = trail_r - 6'd1;
          end
          if (rem_r == 7'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_TERM: begin
        if (adv) begin
          emit                = 1'b1;
          out_nxt.out_char    = CH_NUL;
          out_nxt.last        = 1'b1;
          out_nxt.finished    = 1'b1;
          out_nxt.total_count = pos_r;
          if (pos_r < bsize) begin
            out_nxt.out_pos = pos_r;
            out_nxt.stored  = 1'b1;
          end else if (bsize != 31'd0) begin
            out_nxt.out_pos = bsize - 31'd1;
            out_nxt.stored  = 1'b1;
          end else begin
            out_nxt.out_pos = pos_r;
            out_nxt.stored  = 1'b0;
          end
          pos_nxt   = 31'd0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Output word register.
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_pop) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= 31'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r   <= cmd_nxt;
    mag_r   <= mag_nxt;
    k_r     <= k_nxt;
    neg_r   <= neg_nxt;
    pl_r    <= pl_nxt;
    len_r   <= len_nxt;
    idx_r   <= idx_nxt;
    lead_r  <= lead_nxt;
    trail_r <= trail_nxt;
    rem_r   <= rem_nxt;
    out_r   <= out_nxt;
    if (dig_we) begin
      dig_r[k_r] <= digit;
    end
  end

  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_r.finished) |-> out_r.last)
    else $error("terminator word without last");
  a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (rem_r != 7'd0))
    else $error("emit state with nothing left");
  a_conv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) |-> (k_r < 4'd10))
    else $error("digit count overran");

endmodule

FILE: design/printf_format_engine_top.sv
// ----------------------------------------------------------------------------
// Format engine top level
// Formats a stream of format bytes, argument words and string bytes into
// output characters with buffer positions.
// ----------------------------------------------------------------------------
// Use: push input words (format byte, argument word or string byte) while
// in_full is low; each accepted word is parsed in the same cycle and, where it
// produces output, queued as one command. Results come out as queue words:
// while out_empty is low the oldest result sits on out_data and is taken by
// out_pop. The last result of each input word carries last; the terminator
// carries finished and the total count.
// A word's command passes through the queue to the emitter, which takes it
// while idle, converts a number to digits (up to ten decimal or eight hex),
// prepares the padding and then emits the characters; the terminator goes
// straight from idle to its output. The single character emitter produces one
// character per cycle while the receiver takes them, and finishes one command
// before it takes the next. A four-deep command queue lets the parser run on.
// If the receiver stalls the emitter holds its word and the queue fills, after
// which in_full rises. Reset empties the queue, returns the parser to literal
// text, the position to zero and buffer_size to 4096.
// ----------------------------------------------------------------------------
module printf_format_engine_top import pfe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  in_item_t          in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [30:0] bsize_r, bsize_nxt;
  logic        q_push, q_full, q_pop, q_empty;
  cmd_t        q_wdata, q_rdata;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_BUFFER_SIZE) ? {1'b0, bsize_r} : 32'd0;
  assign bsize_nxt  = (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                       cfg_paddr[2] == REG_BUFFER_SIZE) ? cfg_pwdata[30:0] : bsize_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r <= BSIZE_RESET;
    end else begin
      bsize_r <= bsize_nxt;
    end
  end

  pfe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  pfe_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .bsize     (bsize_r),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

FILE: dv/pfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format engine checker
// Watches the input, result and configuration ports of the format engine,
// predicts every result word from the accepted input words and compares each
// popped result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pfe_checker import pfe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  in_item_t          in_data,
  input  logic              out_empty,
  input  logic              out_pop,
  input  out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic              cfg_pready,
  output int                pending,
  output int                errors
);

  typedef enum logic [2:0] {PH_LIT, PH_FLAGS, PH_WIDTH, PH_ARG, PH_STR} parse_t;
  typedef enum logic [2:0] {K_DEC, K_UDEC, K_HEXL, K_HEXU, K_PTR, K_CHR, K_STR} conv_t;

  localparam int RES_CAP = 63;

  // Model state of the formatter.
  logic [30:0] buf_size;
  parse_t      parse_ph;
  logic        zero_pad;
  logic        left_al;
  logic [5:0]  fwidth;
  conv_t       conv;
  logic [30:0] char_pos;
  logic [31:0] str_left;
  logic [5:0]  tail_pad;
  int          n_made;

  // Expected result words, oldest first.
  out_item_t   expected_chars[$];

  task automatic mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void emit_char(input logic [7:0] c);
    out_item_t r;
    if (n_made >= RES_CAP) return;
    r = '0;
    r.out_char = c;
    r.out_pos  = char_pos;
    r.stored   = ({1'b0, char_pos} + 32'd1) < {1'b0, buf_size};
    if (char_pos != POS_MAX) char_pos++;
    expected_chars.push_back(r);
    n_made++;
  endfunction

  function automatic void emit_pad(input int unsigned cnt, input logic [7:0] c);
    for (int unsigned i = 0; i < cnt; i++) emit_char(c);
  endfunction

  function automatic void end_spec();
    zero_pad = 1'b0;
    left_al  = 1'b0;
    fwidth   = '0;
    parse_ph = PH_LIT;
  endfunction

  // A padded field: padding in front unless left aligned, behind otherwise.
  function automatic void emit_field(input logic [7:0] txt[$]);
    int unsigned pad;
    pad = (fwidth > txt.size()) ? fwidth - txt.size() : 0;
    if (!left_al) emit_pad(pad, zero_pad ? CH_ZERO : CH_SPACE);
    foreach (txt[i]) emit_char(txt[i]);
    if (left_al) emit_pad(pad, CH_SPACE);
    end_spec();
  endfunction

  // Terminator: lands at the position, or at the last byte of a full buffer.
  function automatic void emit_term();
    out_item_t r;
    if (n_made >= RES_CAP) return;
    r = '0;
    if (char_pos < buf_size) begin
      r.out_pos = char_pos;
      r.stored  = 1'b1;
    end else if (buf_size != 0) begin
      r.out_pos = buf_size - 31'd1;
      r.stored  = 1'b1;
    end else begin
      r.out_pos = char_pos;
    end
    r.finished    = 1'b1;
    r.total_count = char_pos;
    expected_chars.push_back(r);
    n_made++;
    end_spec();
    conv     = K_DEC;
    char_pos = '0;
    str_left = '0;
    tail_pad = '0;
  endfunction

  function automatic void take_format(input logic [7:0] c);
    int unsigned w;
    if (c == CH_NUL) begin
      if (parse_ph inside {PH_LIT, PH_FLAGS, PH_WIDTH}) emit_term();
      return;
    end
    if (parse_ph == PH_LIT) begin
      if (c == CH_PCT) parse_ph = PH_FLAGS;
      else emit_char(c);
      return;
    end
    if (parse_ph == PH_FLAGS) begin
      if (c == CH_ZERO) begin
        zero_pad = 1'b1;
        return;
      end
      if (c == CH_MINUS) begin
        left_al = 1'b1;
        return;
      end
      parse_ph = PH_WIDTH;
    end
    if (parse_ph != PH_WIDTH) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      w = fwidth * 10 + (c - CH_ZERO);
      fwidth = (w > MAX_WIDTH) ? MAX_WIDTH : w[5:0];
      return;
    end
    if (left_al) zero_pad = 1'b0;
    parse_ph = PH_ARG;
    case (c)
      CH_D, CH_I: conv = K_DEC;
      CH_U:       conv = K_UDEC;
      CH_LX:      conv = K_HEXL;
      CH_UX:      conv = K_HEXU;
      CH_P:       conv = K_PTR;
      CH_C:       conv = K_CHR;
      CH_S:       conv = K_STR;
      CH_PCT: begin
        emit_char(CH_PCT);
        end_spec();
      end
      default: begin
        emit_char(CH_PCT);
        emit_char(c);
        end_spec();
      end
    endcase
  endfunction

  function automatic void take_arg(input logic [31:0] v, input logic is_null);
    logic [7:0]  txt[$];
    logic [31:0] mag;
    int unsigned pad;
    string       nul_txt;
    nul_txt = "(null)";
    mag = v;
    case (conv)
      K_DEC, K_UDEC: begin
        if (conv == K_DEC && v[31]) mag = -v;
        do begin
          txt.push_front(CH_ZERO + 8'(mag % 10));
          mag = mag / 10;
        end while (mag != 0);
        if (conv == K_DEC && v[31]) txt.push_front(CH_MINUS);
        emit_field(txt);
      end
      K_HEXL, K_HEXU, K_PTR: begin
        do begin
          if (mag[3:0] < 10) txt.push_front(CH_ZERO + 8'(mag[3:0]));
          else if (conv == K_HEXU) txt.push_front(8'h41 + 8'(mag[3:0] - 10));
          else txt.push_front(8'h61 + 8'(mag[3:0] - 10));
          mag = mag >> 4;
        end while (mag != 0);
        if (conv == K_PTR) begin
          txt.push_front(CH_LX);
          txt.push_front(CH_ZERO);
        end
        emit_field(txt);
      end
      K_CHR: begin
        txt.push_back(v[7:0]);
        emit_field(txt);
      end
      default: begin
        if (is_null) begin
          for (int i = 0; i < nul_txt.len(); i++) txt.push_back(nul_txt[i]);
          emit_field(txt);
        end else begin
          pad = ({26'd0, fwidth} > v) ? fwidth - v : 0;
          if (!left_al) emit_pad(pad, zero_pad ? CH_ZERO : CH_SPACE);
          if (v == 0) begin
            if (left_al) emit_pad(pad, CH_SPACE);
            end_spec();
          end else begin
            str_left = v;
            tail_pad = left_al ? pad[5:0] : '0;
            parse_ph = PH_STR;
          end
        end
      end
    endcase
  endfunction

  // Works out every result word that one accepted input word causes.
  function automatic void predict_word(input in_item_t w);
    n_made = 0;
    if (w.opcode == OP_FMT) begin
      take_format(w.data_byte);
    end else if (w.opcode == OP_ARG) begin
      if (parse_ph == PH_ARG) take_arg(w.arg_value, w.arg_null);
    end else if (w.opcode == OP_STR) begin
      if (parse_ph == PH_STR) begin
        emit_char(w.data_byte);
        if (str_left != 0) str_left--;
        if (str_left == 0) begin
          emit_pad(32'(tail_pad), CH_SPACE);
          tail_pad = '0;
          end_spec();
        end
      end
    end
    if (n_made > 0) expected_chars[expected_chars.size() - 1].last = 1'b1;
  endfunction

  // Watch the ports at each rising edge.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      errors   = 0;
      buf_size = BSIZE_RESET;
      end_spec();
      conv     = K_DEC;
      char_pos = '0;
      str_left = '0;
      tail_pad = '0;
      expected_chars.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_BUFFER_SIZE) begin
        buf_size = cfg_pwdata[30:0];
      end
      if (out_pop && !out_empty) begin
        if (expected_chars.size() == 0) begin
          mismatch("unexpected word", 32'(out_data.out_char), 32'd0);
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char != want.out_char)
            mismatch("out_char", 32'(out_data.out_char), 32'(want.out_char));
          if (out_data.out_pos != want.out_pos)
            mismatch("out_pos", 32'(out_data.out_pos), 32'(want.out_pos));
          if (out_data.stored != want.stored)
            mismatch("stored", 32'(out_data.stored), 32'(want.stored));
          if (out_data.last != want.last)
            mismatch("last", 32'(out_data.last), 32'(want.last));
          if (out_data.finished != want.finished)
            mismatch("finished", 32'(out_data.finished), 32'(want.finished));
          if (out_data.total_count != want.total_count)
            mismatch("total_count", 32'(out_data.total_count), 32'(want.total_count));
        end
      end
      if (in_push && !in_full) predict_word(in_data);
    end
    pending = expected_chars.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format engine testbench
// Drives format bytes, argument words and string bytes into the format
// engine: a directed set of corner cases, then random formats
// mixed with stray words, under several buffer sizes and idling patterns.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
  import pfe_pkg::*;

  localparam int LIMIT = 1000000;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  in_item_t          in_data;
  logic              out_empty;
  logic              out_pop;
  out_item_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int pending;
  int errors;
  int cycles = 0;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  bit hold_seen;
  int hold_len;
  int n_words;

  printf_format_engine_top i_dut (.*);

  pfe_checker i_checker (.*);

  // Clock.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off each time one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      hold_seen = hold_req;
      hold_len  = 0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_len  = 400;
      out_pop <= 1'b0;
    end else if (hold_len > 0) begin
      out_pop <= 1'b0;
      hold_len--;
    end else begin
      out_pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one word until an edge accepts it, then at times drops in_push.
  task automatic push_word(input logic [1:0] op, input logic [7:0] b,
                           input logic [31:0] v, input logic nul);
    in_item_t w;
    w.opcode    = op;
    w.data_byte = b;
    w.arg_value = v;
    w.arg_null  = nul;
    in_push <= 1'b1;
    in_data <= w;
    @(negedge clk);
    while (in_full) @(negedge clk);
    @(posedge clk);
    n_words++;
    if ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_word(OP_FMT, s[i], $urandom, 1'($urandom_range(1)));
  endtask

  task automatic send_arg(input logic [31:0] v, input logic nul);
    push_word(OP_ARG, 8'($urandom), v, nul);
  endtask

  task automatic send_bytes(input int cnt);
    for (int i = 0; i < cnt; i++)
      push_word(OP_STR, 8'($urandom_range(255)), $urandom, 1'b0);
  endtask

  task automatic send_end();
    push_word(OP_FMT, CH_NUL, $urandom, 1'($urandom_range(1)));
  endtask

  // Waits until every expected word has come, then lets the engine settle.
  task automatic drain();
    in_push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_bsize(input logic [30:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(4 * REG_BUFFER_SIZE);
    cfg_pwdata  <= {1'b0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_int();
    case ($urandom_range(4))
      0:       return $urandom_range(9);
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One random format: literals and conversions with their arguments.
  task automatic random_format();
    logic [7:0] c;
    logic [7:0] convs[10];
    int         len;
    bit         has_width;
    convs = '{CH_D, CH_I, CH_U, CH_LX, CH_UX, CH_P, CH_C, CH_S, CH_PCT, 8'h71};
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(0, 3)) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_PCT);
        push_word(OP_FMT, c, $urandom, 1'b0);
      end
      push_word(OP_FMT, CH_PCT, $urandom, 1'b0);
      if ($urandom_range(3) == 0) push_word(OP_FMT, CH_ZERO, 0, 1'b0);
      if ($urandom_range(3) == 0) push_word(OP_FMT, CH_MINUS, 0, 1'b0);
      has_width = 1'($urandom_range(1));
      if (has_width) push_word(OP_FMT, 8'(CH_ZERO + $urandom_range(1, 9)), 0, 1'b0);
      if (has_width && $urandom_range(5) == 0)
        push_word(OP_FMT, 8'(CH_ZERO + $urandom_range(9)), 0, 1'b0);
      c = convs[$urandom_range(9)];
      if (c == 8'h71 && has_width && $urandom_range(1)) c = CH_MINUS;
      push_word(OP_FMT, c, 0, 1'b0);
      if (c == CH_S) begin
        if ($urandom_range(7) == 0) begin
          send_arg($urandom_range(20), 1'b1);
        end else begin
          len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
          send_arg(len, 1'b0);
          send_bytes(len);
        end
      end else if (c != CH_PCT && c != 8'h71 && c != CH_MINUS) begin
        send_arg(rand_int(), 1'b0);
      end
    end
    send_end();
  endtask

  // Stray words: wrong opcodes for the phase, and the unused opcode.
  task automatic noise_word();
    push_word(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom_range(8),
              1'($urandom_range(1)));
  endtask

  initial begin
    logic [30:0] sizes[5];
    rst_n       <= 1'b0;
    in_push     <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    n_words   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: extremes of integers, every conversion but %i and the odd cases.
    send_text("%05d");
    send_arg(32'h8000_0000, 1'b0);
    send_text("%-8x%X%p");
    send_arg(32'hDEAD_BEEF, 1'b0);
    send_arg(32'hFFFF_FFFF, 1'b0);
    send_arg(32'h0, 1'b0);
    send_text("%0-4c");
    send_arg(32'hFFFF_FF41, 1'b0);
    send_text("%7s%s%-3s");
    send_arg(0, 1'b1);
    send_arg(0, 1'b0);
    send_arg(2, 1'b0);
    send_bytes(2);
    send_text("%%%q%5-%999u");
    send_arg(32'd4294967295, 1'b0);
    push_word(OP_RSVD, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_arg(1, 1'b0);
    send_bytes(1);
    send_text("%0");
    send_end();
    drain();

    // Random formats under several buffer sizes and idling patterns.
    sizes = '{31'd0, 31'd1, 31'd5, POS_MAX, 31'd17};
    for (int ph = 0; ph < 5; ph++) begin
      write_bsize((ph == 4) ? 31'($urandom_range(2, 60)) : sizes[ph]);
      idle_pct  = (ph == 1 || ph == 3) ? 74 : (ph == 4) ? 16 : 0;
      stall_pct = (ph == 2 || ph == 3) ? 74 : (ph == 4) ? 16 : 0;
      if (ph == 0) hold_req = ~hold_req;
      while (n_words < 40 + 56 * (ph + 1)) begin
        if ($urandom_range(9) == 0) noise_word();
        else random_format();
        if (ph == 2 && n_words > 175 && n_words < 187) drain();
      end
      drain();
    end
    write_bsize(BSIZE_RESET);
    random_format();
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
